FILE: src/rvdec_pkg.sv
// Shared types and constants for the RV32I instruction decoder.
package rvdec_pkg;

   // Major opcodes of the RV32I base set.
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;

   // Funct3 codes that select the alternate forms.
   localparam logic [2:0] F3_ADD_SUB = 3'd0;
   localparam logic [2:0] F3_SLL     = 3'd1;
   localparam logic [2:0] F3_SRL_SRA = 3'd5;

   // Mnemonic codes.
   localparam logic [5:0] MN_LUI     = 6'd0;
   localparam logic [5:0] MN_AUIPC   = 6'd1;
   localparam logic [5:0] MN_JAL     = 6'd2;
   localparam logic [5:0] MN_JALR    = 6'd3;
   localparam logic [5:0] MN_BEQ     = 6'd4;
   localparam logic [5:0] MN_BNE     = 6'd5;
   localparam logic [5:0] MN_BLT     = 6'd6;
   localparam logic [5:0] MN_BGE     = 6'd7;
   localparam logic [5:0] MN_BLTU    = 6'd8;
   localparam logic [5:0] MN_BGEU    = 6'd9;
   localparam logic [5:0] MN_LB      = 6'd10;
   localparam logic [5:0] MN_LH      = 6'd11;
   localparam logic [5:0] MN_LW      = 6'd12;
   localparam logic [5:0] MN_LBU     = 6'd13;
   localparam logic [5:0] MN_LHU     = 6'd14;
   localparam logic [5:0] MN_SB      = 6'd15;
   localparam logic [5:0] MN_SH      = 6'd16;
   localparam logic [5:0] MN_SW      = 6'd17;
   localparam logic [5:0] MN_ADDI    = 6'd18;
   localparam logic [5:0] MN_SLTI    = 6'd19;
   localparam logic [5:0] MN_SLTIU   = 6'd20;
   localparam logic [5:0] MN_XORI    = 6'd21;
   localparam logic [5:0] MN_ORI     = 6'd22;
   localparam logic [5:0] MN_ANDI    = 6'd23;
   localparam logic [5:0] MN_SLLI    = 6'd24;
   localparam logic [5:0] MN_SRLI    = 6'd25;
   localparam logic [5:0] MN_SRAI    = 6'd26;
   localparam logic [5:0] MN_ADD     = 6'd27;
   localparam logic [5:0] MN_SUB     = 6'd28;
   localparam logic [5:0] MN_SLL     = 6'd29;
   localparam logic [5:0] MN_SLT     = 6'd30;
   localparam logic [5:0] MN_SLTU    = 6'd31;
   localparam logic [5:0] MN_XOR     = 6'd32;
   localparam logic [5:0] MN_SRL     = 6'd33;
   localparam logic [5:0] MN_SRA     = 6'd34;
   localparam logic [5:0] MN_OR      = 6'd35;
   localparam logic [5:0] MN_AND     = 6'd36;
   localparam logic [5:0] MN_UNKNOWN = 6'd37;

   // Funct3 lookup tables, indexed by funct3.
   localparam logic [5:0] BRANCH_MAP [8] = '{MN_BEQ, MN_BNE, MN_UNKNOWN, MN_UNKNOWN,
                                             MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};
   localparam logic [5:0] LOAD_MAP [8]   = '{MN_LB, MN_LH, MN_LW, MN_UNKNOWN,
                                             MN_LBU, MN_LHU, MN_UNKNOWN, MN_UNKNOWN};
   localparam logic [5:0] STORE_MAP [8]  = '{MN_SB, MN_SH, MN_SW, MN_UNKNOWN,
                                             MN_UNKNOWN, MN_UNKNOWN, MN_UNKNOWN,
                                             MN_UNKNOWN};
   localparam logic [5:0] OPIMM_MAP [8]  = '{MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU,
                                             MN_XORI, MN_SRLI, MN_ORI, MN_ANDI};
   localparam logic [5:0] OP_MAP [8]     = '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU,
                                             MN_XOR, MN_SRL, MN_OR, MN_AND};

   // Input word payload.
   typedef struct packed {
      logic [31:0] instr_word;
   } req_type;

   // Decoded result payload.
   typedef struct packed {
      logic [5:0]         mnemonic;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_a;
      logic [4:0]         src_reg_b;
      logic signed [31:0] immediate;
   } rsp_type;

endpackage

FILE: src/rvdec_chan_if.sv
// Valid/ready channel interface that carries one payload word per handshake.
interface rvdec_chan_if #(parameter type payload_type = logic [31:0]) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

FILE: src/rvdec_decode.sv
// Combinational field extraction and mnemonic decode of one RV32I word.
module rvdec_decode (
   input  logic [31:0]       instr_word,
   output rvdec_pkg::rsp_type result
);
   import rvdec_pkg::*;

   logic [6:0]  opcode;
   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [4:0]  rd;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [5:0]  mn;
   logic [4:0]  o_rd;
   logic [4:0]  o_rs1;
   logic [4:0]  o_rs2;
   logic [31:0] o_imm;

   // Fixed bit fields of the word.
   assign opcode = instr_word[6:0];
   assign rd     = instr_word[11:7];
   assign funct3 = instr_word[14:12];
   assign rs1    = instr_word[19:15];
   assign rs2    = instr_word[24:20];
   assign funct7 = instr_word[31:25];

   // Sign-extended immediates of every format.
   assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
   assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
   assign imm_u = {instr_word[31:12], 12'd0};
   assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                   instr_word[20], instr_word[30:21], 1'b0};

   // Dispatch on the major opcode.
   always_comb begin
      mn    = MN_UNKNOWN;
      o_rd  = 5'd0;
      o_rs1 = 5'd0;
      o_rs2 = 5'd0;
      o_imm = 32'd0;
      unique case (opcode)
         OPC_LUI: begin
            mn    = MN_LUI;
            o_rd  = rd;
            o_imm = imm_u;
         end
         OPC_AUIPC: begin
            mn    = MN_AUIPC;
            o_rd  = rd;
            o_imm = imm_u;
         end
         OPC_JAL: begin
            mn    = MN_JAL;
            o_rd  = rd;
            o_imm = imm_j;
         end
         OPC_JALR: begin
            mn    = MN_JALR;
            o_rd  = rd;
            o_rs1 = rs1;
            o_imm = imm_i;
         end
         OPC_BRANCH: begin
            mn    = BRANCH_MAP[funct3];
            o_rs1 = rs1;
            o_rs2 = rs2;
            o_imm = imm_b;
         end
         OPC_LOAD: begin
            mn    = LOAD_MAP[funct3];
            o_rd  = rd;
            o_rs1 = rs1;
            o_imm = imm_i;
         end
         OPC_STORE: begin
            mn    = STORE_MAP[funct3];
            o_rs1 = rs1;
            o_rs2 = rs2;
            o_imm = imm_s;
         end
         OPC_OP_IMM: begin
            mn    = OPIMM_MAP[funct3];
            // Either of the two top bits turns a right shift into srai.
            if (funct3 == F3_SRL_SRA && (instr_word[30] || instr_word[31])) begin
               mn = MN_SRAI;
            end
            o_rd  = rd;
            o_rs1 = rs1;
            // Shifts carry the shift amount, zero-extended.
            if (funct3 == F3_SLL || funct3 == F3_SRL_SRA) begin
               o_imm = {27'd0, rs2};
            end else begin
               o_imm = imm_i;
            end
         end
         OPC_OP: begin
            mn = OP_MAP[funct3];
            // Any nonzero funct7 selects sub or sra.
            if (funct7 != 7'd0 && (funct3 == F3_ADD_SUB || funct3 == F3_SRL_SRA)) begin
               mn = mn + 6'd1;
            end
            o_rd  = rd;
            o_rs1 = rs1;
            o_rs2 = rs2;
         end
         default: begin
            mn = MN_UNKNOWN;
         end
      endcase
   end

   // An unknown word reports all other fields as zero.
   always_comb begin
      result.mnemonic = mn;
      if (mn == MN_UNKNOWN) begin
         result.dest_reg  = 5'd0;
         result.src_reg_a = 5'd0;
         result.src_reg_b = 5'd0;
         result.immediate = 32'sd0;
      end else begin
         result.dest_reg  = o_rd;
         result.src_reg_a = o_rs1;
         result.src_reg_b = o_rs2;
         result.immediate = $signed(o_imm);
      end
   end

endmodule

FILE: src/rv32i_instruction_decoder.sv
// Each request word is registered in the input stage, then in the result stage.
// One word per cycle if unstalled; on a stall an empty input takes a new word.
// Both stages hand off by valid/ready, so a stalled response holds its word.
// Rate is set by the single decode pass between the input and result registers.
// Synchronous active-high reset empties both stages; payload registers keep data.
module rv32i_instruction_decoder (
   input logic          clock,
   input logic          reset,
   rvdec_chan_if.sink   req_chan,
   rvdec_chan_if.source rsp_chan
);
   import rvdec_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] in_word_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   rsp_type     out_word_ff;
   rsp_type     decoded;
   logic        req_fire;
   logic        stage_fire;
   logic        out_open;

   // Handshake control: each stage moves when the stage after it has room.
   assign out_open     = !out_valid_ff || rsp_chan.ready;
   assign stage_fire   = in_valid_ff && out_open;
   assign req_chan.ready = !in_valid_ff || out_open;
   assign req_fire     = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !stage_fire);
   assign out_valid_in = stage_fire || (out_valid_ff && !rsp_chan.ready);

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register captures the request word.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_chan.payload.instr_word;
      end
   end

   // Decode between the two registers.
   rvdec_decode u_decode (
      .instr_word (in_word_ff),
      .result     (decoded)
   );

   // Result register captures the decoded word.
   always_ff @(posedge clock) begin
      if (stage_fire) begin
         out_word_ff <= decoded;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   // An accepted word always occupies the input stage next cycle.
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted word lost from input stage");

   // An unknown word carries only zero fields.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.mnemonic == MN_UNKNOWN) |->
      (rsp_chan.payload.dest_reg == 5'd0 && rsp_chan.payload.src_reg_a == 5'd0 &&
       rsp_chan.payload.src_reg_b == 5'd0 && rsp_chan.payload.immediate == 32'sd0))
      else $error("unknown word with nonzero fields");

   // Branches and stores have no destination register.
   a_no_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && ((rsp_chan.payload.mnemonic >= MN_BEQ &&
                           rsp_chan.payload.mnemonic <= MN_BGEU) ||
                          (rsp_chan.payload.mnemonic >= MN_SB &&
                           rsp_chan.payload.mnemonic <= MN_SW))) |->
      rsp_chan.payload.dest_reg == 5'd0)
      else $error("branch or store with a destination register");

   // Upper-immediate and jump words have no first source register.
   a_no_src_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.payload.mnemonic == MN_LUI ||
                          rsp_chan.payload.mnemonic == MN_AUIPC ||
                          rsp_chan.payload.mnemonic == MN_JAL)) |->
      rsp_chan.payload.src_reg_a == 5'd0)
      else $error("upper-immediate or jump with a source register");

endmodule
